@@ rtl/bmwf_pkg.sv @@
`timescale 1ns / 1ps

package bmwf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int DIM_W  = 12;  // width / height register
  localparam int THR_W  = 5;
  localparam int ROW_W  = 12;  // input row runs a few rows past the image
  localparam int OROW_W = 11;
  localparam int LINE_W = 4;   // rows kept per column
  localparam int WIN_W  = 25;
  localparam int CNT_W  = 5;

  localparam int WIDTH_RESET  = 2048;
  localparam int HEIGHT_RESET = 2048;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 5'd12;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd2;

  typedef struct packed {
    logic req_type;
    logic pixel;
  } in_word_t;

  typedef struct packed {
    logic filtered_pixel;
    logic end_of_row;
    logic end_of_frame;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     value;
  } cfg_word_t;

  // per-column control handed from the scan stage to the column stage
  typedef struct packed {
    logic              pixel;
    logic [LINE_W-1:0] row_mask;
    logic              emit;
    logic              end_of_row;
    logic              end_of_frame;
    logic [4:0]        slot_mask;
  } col_ctl_t;

endpackage

@@ rtl/bmwf_chan_if.sv @@
`timescale 1ns / 1ps

interface bmwf_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bmwf_line_store.sv @@
`timescale 1ns / 1ps

module bmwf_line_store #(
  parameter int DEPTH = bmwf_pkg::MAX_WIDTH,
  localparam int AddrW = $clog2(DEPTH),
  localparam int DataW = bmwf_pkg::LINE_W
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rd_data_q;

  // read returns the old word on a same-address write; caller forwards
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/bmwf_scan.sv @@
`timescale 1ns / 1ps

module bmwf_scan #(
  parameter int MAX_WIDTH = bmwf_pkg::MAX_WIDTH,
  localparam int ColW = $clog2(MAX_WIDTH),
  localparam int WidW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  bmwf_pkg::cfg_word_t           cfg_word_i,
  output logic                          clear_o,
  output logic [bmwf_pkg::THR_W-1:0]    thr_o,
  input  logic                          acc_i,
  input  bmwf_pkg::in_word_t            in_word_i,
  output logic                          load_o,
  output logic [ColW-1:0]               addr_o,
  output bmwf_pkg::col_ctl_t            ctl_o
);

  localparam int DimW  = bmwf_pkg::DIM_W;
  localparam int RowW  = bmwf_pkg::ROW_W;
  localparam int ORowW = bmwf_pkg::OROW_W;
  localparam int LineW = bmwf_pkg::LINE_W;

  localparam logic [DimW:0]   MaxWidthX = (DimW + 1)'(MAX_WIDTH);
  localparam logic [WidW-1:0] WidthMax  = WidW'(MAX_WIDTH);
  localparam logic [WidW-1:0] WidthRst  = (bmwf_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                          WidthMax : WidW'(bmwf_pkg::WIDTH_RESET);
  localparam logic [DimW-1:0] HeightMax = DimW'(bmwf_pkg::MAX_HEIGHT);
  localparam logic [DimW-1:0] HeightRst = DimW'(bmwf_pkg::HEIGHT_RESET);

  logic [WidW-1:0]            width_q;
  logic [DimW-1:0]            height_q;
  logic [bmwf_pkg::THR_W-1:0] thr_q;
  logic [ColW-1:0]            icol_q;
  logic [RowW-1:0]            irow_q;
  logic [ColW-1:0]            ocol_q;
  logic [ORowW-1:0]           orow_q;

  logic            cfg_hit;
  logic [WidW-1:0] width_new;
  logic [DimW-1:0] height_new;
  logic            idle_drain;
  logic            emit, eor, eof;
  logic [WidW-1:0] icol_p1, ocol_p1;
  logic [WidW:0]   opos;
  logic [LineW-1:0] row_mask;
  logic [4:0]      slot_mask;

  assign cfg_hit = cfg_we_i &&
                   (cfg_word_i.index == bmwf_pkg::REG_IMAGE_WIDTH ||
                    cfg_word_i.index == bmwf_pkg::REG_IMAGE_HEIGHT ||
                    cfg_word_i.index == bmwf_pkg::REG_COUNT_THRESHOLD);

  always_comb begin
    if (cfg_word_i.value == '0) begin
      width_new = WidW'(1);
    end else if ({1'b0, cfg_word_i.value} > MaxWidthX) begin
      width_new = WidthMax;
    end else begin
      width_new = WidW'(cfg_word_i.value);
    end
    if (cfg_word_i.value == '0) begin
      height_new = DimW'(1);
    end else if (cfg_word_i.value > HeightMax) begin
      height_new = HeightMax;
    end else begin
      height_new = cfg_word_i.value;
    end
  end

  // a drain before the first pixel of a frame is swallowed
  assign idle_drain = in_word_i.req_type && (irow_q == '0) && (icol_q == '0);
  assign load_o     = acc_i && !idle_drain;

  // linear position >= 2*width+2, written without the multiply
  assign emit = (irow_q >= RowW'(4)) ||
                ((irow_q == RowW'(3)) && (width_q >= WidW'(2))) ||
                ((irow_q == RowW'(2)) && (icol_q >= ColW'(2)));

  assign icol_p1 = WidW'(icol_q) + WidW'(1);
  assign ocol_p1 = WidW'(ocol_q) + WidW'(1);
  assign opos    = (WidW + 1)'(ocol_q) + (WidW + 1)'(2);
  assign eor     = emit && (ocol_p1 >= width_q);
  assign eof     = eor && (({1'b0, orow_q} + DimW'(1)) >= height_q);

  always_comb begin
    for (int j = 0; j < LineW; j++) begin
      row_mask[j] = irow_q >= RowW'(j + 1);
    end
    // window slot k covers output column ocol + 2 - k
    for (int k = 0; k < 5; k++) begin
      slot_mask[k] = (opos >= (WidW + 1)'(k)) &&
                     ((opos - (WidW + 1)'(k)) < (WidW + 1)'(width_q));
    end
  end

  always_comb begin
    ctl_o.pixel        = in_word_i.pixel && !in_word_i.req_type &&
                         ((DimW + 1)'(irow_q) < (DimW + 1)'(height_q));
    ctl_o.row_mask     = row_mask;
    ctl_o.emit         = emit;
    ctl_o.end_of_row   = eor;
    ctl_o.end_of_frame = eof;
    ctl_o.slot_mask    = slot_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      thr_q    <= bmwf_pkg::THRESHOLD_RESET;
      icol_q   <= '0;
      irow_q   <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_word_i.index)
        bmwf_pkg::REG_IMAGE_WIDTH:     width_q  <= width_new;
        bmwf_pkg::REG_IMAGE_HEIGHT:    height_q <= height_new;
        bmwf_pkg::REG_COUNT_THRESHOLD: thr_q    <= cfg_word_i.value[bmwf_pkg::THR_W-1:0];
        default: ;
      endcase
      if (cfg_hit) begin
        icol_q <= '0;
        irow_q <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end
    end else if (load_o) begin
      if (eof) begin
        icol_q <= '0;
        irow_q <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        if (icol_p1 >= width_q) begin
          icol_q <= '0;
          irow_q <= irow_q + RowW'(1);
        end else begin
          icol_q <= icol_q + ColW'(1);
        end
        if (eor) begin
          ocol_q <= '0;
          orow_q <= orow_q + ORowW'(1);
        end else if (emit) begin
          ocol_q <= ocol_q + ColW'(1);
        end
      end
    end
  end

  assign clear_o = cfg_hit;
  assign thr_o   = thr_q;
  assign addr_o  = icol_q;

endmodule

@@ rtl/bmwf_window.sv @@
`timescale 1ns / 1ps

module bmwf_window #(
  parameter int MAX_WIDTH = bmwf_pkg::MAX_WIDTH,
  localparam int ColW = $clog2(MAX_WIDTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic [bmwf_pkg::THR_W-1:0]   thr_i,
  input  logic                         load_i,
  input  logic [ColW-1:0]              addr_i,
  input  bmwf_pkg::col_ctl_t           ctl_i,
  output logic                         ready_o,
  input  logic [bmwf_pkg::LINE_W-1:0]  rd_data_i,
  output logic                         wr_en_o,
  output logic [ColW-1:0]              wr_addr_o,
  output logic [bmwf_pkg::LINE_W-1:0]  wr_data_o,
  output logic                         out_valid_o,
  output bmwf_pkg::out_word_t          out_word_o,
  input  logic                         out_ready_i
);

  localparam int LineW = bmwf_pkg::LINE_W;
  localparam int WinW  = bmwf_pkg::WIN_W;
  localparam int CntW  = bmwf_pkg::CNT_W;

  function automatic logic [2:0] count5(input logic [4:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 5; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

  logic                s1_valid_q;
  bmwf_pkg::col_ctl_t  s1_ctl_q;
  logic [ColW-1:0]     s1_addr_q;
  logic                fwd_q;
  logic [LineW-1:0]    fwd_data_q;
  logic [WinW-1:0]     win_q;
  logic                out_valid_q;
  bmwf_pkg::out_word_t out_word_q;

  logic             fire;
  logic [LineW-1:0] above;
  logic [4:0]       col;
  logic [WinW-1:0]  win_new;
  logic [CntW-1:0]  cnt;

  assign fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || fire;

  // w == 1: the next word reads the column being written this cycle
  assign above   = fwd_q ? fwd_data_q : rd_data_i;
  assign col     = {above & s1_ctl_q.row_mask, s1_ctl_q.pixel};
  assign win_new = {win_q[WinW-6:0], col};

  always_comb begin
    cnt = '0;
    for (int k = 0; k < 5; k++) begin
      if (s1_ctl_q.slot_mask[k]) begin
        cnt = cnt + CntW'(count5(win_new[5*k +: 5]));
      end
    end
  end

  assign wr_en_o   = fire;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = col[LineW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= fire && (s1_addr_q == addr_i);
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (clear_i) begin
        win_q <= '0;
      end else if (fire) begin
        win_q <= s1_ctl_q.end_of_frame ? '0 : win_new;
      end
      if (fire && s1_ctl_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_ctl_q   <= ctl_i;
      s1_addr_q  <= addr_i;
      fwd_data_q <= col[LineW-1:0];
    end
    if (fire && s1_ctl_q.emit) begin
      out_word_q.filtered_pixel <= cnt > thr_i;
      out_word_q.end_of_row     <= s1_ctl_q.end_of_row;
      out_word_q.end_of_frame   <= s1_ctl_q.end_of_frame;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ rtl/binary_majority_window_filter.sv @@
`timescale 1ns / 1ps

// channel  dir  word                              handshake
// in_i     in   req_type, pixel                   valid/ready
// out_o    out  filtered_pixel, end_of_row/frame  valid/ready
// cfg_i    in   index, value                      valid/ready (always ready)
//
// One word per clock: the scan stage issues the line-store read as a word is
// taken, the column stage merges the registered read data, writes it back and
// counts the 5x5 window. The result is registered again before it shows at out_o.
// Reset clears counters, window and valid bits; the line store is not cleared,
// rows above are masked by the row counter. Stalls on out_o hold the column
// stage; in_i keeps taking words while the column stage can move.
module binary_majority_window_filter #(
  parameter int MAX_WIDTH = bmwf_pkg::MAX_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmwf_chan_if.sink   in_i,
  bmwf_chan_if.source out_o,
  bmwf_chan_if.sink   cfg_i
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int LineW = bmwf_pkg::LINE_W;

  logic                       cfg_we;
  logic                       clear;
  logic [bmwf_pkg::THR_W-1:0] thr;
  logic                       acc;
  logic                       load;
  logic                       ready;
  logic [ColW-1:0]            addr;
  bmwf_pkg::col_ctl_t         ctl;
  logic [LineW-1:0]           rd_data;
  logic                       wr_en;
  logic [ColW-1:0]            wr_addr;
  logic [LineW-1:0]           wr_data;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = ready;
  assign acc         = in_i.valid && ready;

  bmwf_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_word_i (cfg_i.data),
    .clear_o    (clear),
    .thr_o      (thr),
    .acc_i      (acc),
    .in_word_i  (in_i.data),
    .load_o     (load),
    .addr_o     (addr),
    .ctl_o      (ctl)
  );

  bmwf_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (load),
    .rd_addr_i (addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  bmwf_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .thr_i       (thr),
    .load_i      (load),
    .addr_i      (addr),
    .ctl_i       (ctl),
    .ready_o     (ready),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

endmodule

@@ rtl/bmwf_checker.sv @@
`timescale 1ns / 1ps

module bmwf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_req_type_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bmwf_pkg::out_word_t out_word_i
);

  logic out_stall;
  assign out_stall = out_valid_i && !out_ready_i;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_i && $stable(out_word_i))
    else $error("out word changed while stalled");

  // a fresh result traces back to a word taken on in_i
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching input word");

  // one pixel taken during a stall fills the column stage
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall && $past(out_stall && in_valid_i && in_ready_i && !in_req_type_i)
    |-> !in_ready_i)
    else $error("input taken with column stage full");

endmodule

bind binary_majority_window_filter bmwf_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_req_type_i (in_i.data.req_type),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_word_i    (out_o.data)
);

@@ tb/binary_majority_window_filter_tb.sv @@
`timescale 1ns / 1ps

module binary_majority_window_filter_tb;
  import bmwf_pkg::*;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on any channel
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 8;
  localparam int RANDOM_WORDS = 1100;

  class majority_scoreboard;
    logic [DIM_W-1:0]  img_w;
    logic [DIM_W-1:0]  img_h;
    logic [THR_W-1:0]  thr;
    logic [LINE_W-1:0] rows_above [MAX_WIDTH];
    logic [WIN_W-1:0]  win;
    logic [ROW_W-1:0]  in_row;
    logic [10:0]       in_col;
    logic [OROW_W-1:0] out_row;
    logic [10:0]       out_col;
    out_word_t         expected_pixels [$];
    int words_taken;
    int results_checked;
    int frames_done;
    int errors;

    function new();
      img_w = DIM_W'(WIDTH_RESET);
      img_h = DIM_W'(HEIGHT_RESET);
      thr   = THRESHOLD_RESET;
      foreach (rows_above[i]) rows_above[i] = '0;
      restart_frame();
      words_taken     = 0;
      results_checked = 0;
      frames_done     = 0;
      errors          = 0;
    endfunction

    function void restart_frame();
      win     = '0;
      in_row  = '0;
      in_col  = '0;
      out_row = '0;
      out_col = '0;
    endfunction

    function int active_width();
      if (img_w == 0) return 1;
      if (img_w > MAX_WIDTH) return MAX_WIDTH;
      return img_w;
    endfunction

    function int active_height();
      if (img_h == 0) return 1;
      if (img_h > MAX_HEIGHT) return MAX_HEIGHT;
      return img_h;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH: img_w = val;
        REG_IMAGE_HEIGHT: img_h = val;
        REG_COUNT_THRESHOLD: thr = val[THR_W-1:0];
        default: return;
      endcase
      // any real write drops the frame in progress
      restart_frame();
    endfunction

    function void predict_pixel(in_word_t w);
      int unsigned wd;
      int unsigned ht;
      int unsigned lin;
      int unsigned cnt;
      int unsigned cpos;
      logic        pix;
      logic [4:0]  rowmask;
      logic [4:0]  col;
      out_word_t   r;
      wd  = active_width();
      ht  = active_height();
      pix = w.pixel;
      if (w.req_type == REQ_DRAIN && in_row == 0 && in_col == 0) return;
      words_taken++;
      if (w.req_type == REQ_DRAIN || in_row >= ht) pix = 1'b0;

      // row k above is valid only once k rows of this frame went by
      rowmask = '0;
      for (int k = 1; k <= 4; k++)
        if (k <= in_row) rowmask[k] = 1'b1;
      col = ({rows_above[in_col], 1'b0} & rowmask) | {4'b0, pix};
      rows_above[in_col] = col[LINE_W-1:0];
      win = {win[WIN_W-6:0], col};

      lin = in_row * wd + in_col;
      if (in_col + 1 >= wd) begin
        in_col = '0;
        in_row++;
      end else begin
        in_col++;
      end
      if (lin < 2 * wd + 2) return;

      // slot k is window column out_col + 2 - k
      cnt = 0;
      for (int k = 0; k < 5; k++) begin
        cpos = out_col + 2;
        if (cpos < k) continue;
        cpos -= k;
        if (cpos >= wd) continue;
        cnt += $countones(win[5*k +: 5]);
      end
      r.filtered_pixel = (cnt > thr);
      r.end_of_row     = (out_col + 1 >= wd);
      r.end_of_frame   = r.end_of_row && (out_row + 1 >= ht);
      expected_pixels.push_back(r);

      if (r.end_of_frame) begin
        restart_frame();
      end else if (r.end_of_row) begin
        out_col = '0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_pixels.size() == 0) begin
        $error("result word %b with nothing expected", got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      results_checked++;
      if (want.end_of_frame) frames_done++;
      if (got.filtered_pixel !== want.filtered_pixel) begin
        $error("filtered_pixel: expected %0b, got %0b", want.filtered_pixel,
               got.filtered_pixel);
        errors++;
      end
      if (got.end_of_row !== want.end_of_row) begin
        $error("end_of_row: expected %0b, got %0b", want.end_of_row, got.end_of_row);
        errors++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        $error("end_of_frame: expected %0b, got %0b", want.end_of_frame,
               got.end_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bmwf_chan_if #(.word_t(in_word_t))  pix_ch ();
  bmwf_chan_if #(.word_t(out_word_t)) res_ch ();
  bmwf_chan_if #(.word_t(cfg_word_t)) cfg_ch ();

  binary_majority_window_filter DUT (
    .clk_i,
    .rst_ni,
    .in_i (pix_ch),
    .out_o(res_ch),
    .cfg_i(cfg_ch)
  );

  majority_scoreboard sb;
  bit calm;
  bit hold_req;
  int idle_cycles;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_ch.valid && pix_ch.ready) sb.predict_pixel(pix_ch.data);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.data.index, cfg_ch.data.value);
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.expected_pixels.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result sink: bursts of stalls, one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          res_ch.ready <= 1'b0;
        end
        hold_req = 1'b0;
      end else begin
        repeat ($urandom_range(1, 20)) begin
          @(negedge clk_i);
          res_ch.ready <= 1'b1;
        end
        if (!calm) begin
          repeat ($urandom_range(1, 5)) begin
            @(negedge clk_i);
            res_ch.ready <= 1'b0;
          end
        end
      end
    end
  end

  task automatic send_word(input logic req, input logic pix);
    if (!calm && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk_i);
        pix_ch.valid <= 1'b0;
        pix_ch.data  <= in_word_t'(2'($urandom_range(0, 3)));
      end
    end
    @(negedge clk_i);
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= in_word_t'{req_type: req, pixel: pix};
    do @(posedge clk_i); while (!pix_ch.ready);
  endtask

  task automatic park_input();
    @(negedge clk_i);
    pix_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfg_word_t'{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // registers only change once the pipe has drained
  task automatic set_frame(input int w_raw, input int h_raw, input int thr_raw);
    park_input();
    wait_for_results();
    repeat (SETTLE) @(posedge clk_i);
    write_cfg(REG_IMAGE_WIDTH, DIM_W'(w_raw));
    write_cfg(REG_IMAGE_HEIGHT, DIM_W'(h_raw));
    write_cfg(REG_COUNT_THRESHOLD, {7'($urandom), THR_W'(thr_raw)});
  endtask

  // one frame: body pixels then the 2w+2 flush words; cut < 0 runs it to the end
  task automatic send_frame(input int dens, input int cut, input bit mid_pause);
    int  w;
    int  h;
    int  body;
    bit  px;
    w    = sb.active_width();
    h    = sb.active_height();
    body = w * h;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) send_word(REQ_DRAIN, 1'($urandom));
    end
    for (int n = 0; n < body + 2 * w + 2; n++) begin
      if (n == cut) break;
      if (mid_pause && n == body / 2) begin
        park_input();
        wait_for_results();
      end
      px = ($urandom_range(1, 8) <= dens);
      if (n < body) begin
        if ($urandom_range(0, 19) == 0) send_word(REQ_DRAIN, px);
        else send_word(REQ_PIXEL, px);
      end else begin
        if ($urandom_range(0, 3) == 0) send_word(REQ_PIXEL, 1'($urandom));
        else send_word(REQ_DRAIN, px);
      end
    end
  endtask

  initial begin
    int base;
    int phase;
    int w_raw;
    int h_raw;
    int thr_raw;
    int nframes;
    int cut;
    int pick;

    rst_ni       = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    idle_cycles  = 0;
    sb           = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle drain, abandoned reset-size frame, 1x1 and 2x2 corners
    send_word(REQ_DRAIN, 1'b1);
    repeat (3) send_word(REQ_PIXEL, 1'b1);
    set_frame(0, 0, 0);
    write_cfg(REG_UNUSED, 12'hFFF);
    send_word(REQ_PIXEL, 1'b1);
    repeat (4) send_word(REQ_DRAIN, 1'b0);
    send_word(REQ_PIXEL, 1'b0);
    send_word(REQ_PIXEL, 1'b1);  // past the image, must read as zero
    repeat (3) send_word(REQ_DRAIN, 1'b1);
    set_frame(2, 2, 2);
    send_word(REQ_PIXEL, 1'b1);
    send_word(REQ_DRAIN, 1'b1);  // drain inside the image is a zero pixel
    send_word(REQ_PIXEL, 1'b1);
    send_word(REQ_PIXEL, 1'b1);
    repeat (6) send_word(REQ_DRAIN, 1'b0);

    // largest sizes, each with a thin other dimension
    set_frame(4095, 1, $urandom_range(0, 3));
    send_frame($urandom_range(2, 8), 200, 1'b0);
    set_frame(1, 4095, $urandom_range(0, 3));
    send_frame($urandom_range(2, 8), 200, 1'b0);
    set_frame(2048, 3, 25);
    send_frame(8, 200, 1'b0);

    base  = sb.words_taken;
    phase = 0;
    while (sb.words_taken - base < RANDOM_WORDS) begin
      calm = (sb.words_taken - base > RANDOM_WORDS * 4 / 5);
      pick = $urandom_range(0, 9);
      w_raw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      h_raw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      pick = $urandom_range(0, 9);
      thr_raw = (pick == 0) ? $urandom_range(26, 31) : (pick == 1) ? 25 :
                (pick == 2) ? 0 : $urandom_range(1, 16);
      if (phase == 0) begin
        w_raw = 16;
        h_raw = 10;
      end
      if (phase == 1) begin
        w_raw = 12;
        h_raw = 8;
      end
      set_frame(w_raw, h_raw, thr_raw);
      if ($urandom_range(0, 7) == 0) write_cfg(REG_UNUSED, DIM_W'($urandom));
      nframes = $urandom_range(1, 3);
      for (int fr = 0; fr < nframes; fr++) begin
        if (phase == 0 && fr == 0) hold_req = 1'b1;
        cut = -1;
        if (fr == nframes - 1 && $urandom_range(0, 4) == 0)
          cut = $urandom_range(0, sb.active_width() * (sb.active_height() + 2) + 1);
        send_frame($urandom_range(0, 8), cut, phase == 1 && fr == 0);
      end
      phase++;
    end

    park_input();
    wait_for_results();
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d pixel/drain words over %0d random setups, %0d results checked",
             sb.words_taken, phase, sb.results_checked);
    $display("%0d full frames, sizes 1x1 up to 2048 wide or high, thresholds 0 to 31",
             sb.frames_done);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bmwf_pkg.sv
rtl/bmwf_chan_if.sv
rtl/bmwf_line_store.sv
rtl/bmwf_scan.sv
rtl/bmwf_window.sv
rtl/binary_majority_window_filter.sv
rtl/bmwf_checker.sv
tb/binary_majority_window_filter_tb.sv
